@@ design/mms_pkg.sv @@
// ----------------------------------------------------------------------------
// mms_pkg
// Types, constants and arithmetic helpers of the model matrix builder.
// ----------------------------------------------------------------------------
package mms_pkg;

  localparam int CORDIC_STAGES = 14;
  localparam int N_STG = (CORDIC_STAGES > 24) ? 24 : CORDIC_STAGES;

  localparam int PI_Q12      = 12868;
  localparam int TWO_PI_Q12  = 25736;
  localparam int PI_Q20      = 3294208;
  localparam int HALF_PI_Q20 = 1647104;
  localparam int GAIN_Q30    = 652032874;
  localparam int ONE_Q16     = 65536;

  typedef logic signed [15:0] angle_t;
  typedef logic signed [23:0] zang_t;
  typedef logic signed [33:0] cw_t;
  typedef logic signed [19:0] trig_t;
  typedef logic signed [31:0] word_t;
  typedef logic signed [51:0] prod_t;

  typedef struct packed {
    word_t scale_x;
    word_t scale_y;
    word_t scale_z;
    word_t pos_x;
    word_t pos_y;
    word_t pos_z;
  } item_t;

  function automatic zang_t atan_q20(input int idx);
    zang_t r;
    unique case (idx)
      0:       r = 24'sd823550;
      1:       r = 24'sd486170;
      2:       r = 24'sd256879;
      3:       r = 24'sd130396;
      4:       r = 24'sd65451;
      5:       r = 24'sd32757;
      6:       r = 24'sd16383;
      7:       r = 24'sd8192;
      8:       r = 24'sd4096;
      9:       r = 24'sd2048;
      10:      r = 24'sd1024;
      11:      r = 24'sd512;
      12:      r = 24'sd256;
      13:      r = 24'sd128;
      14:      r = 24'sd64;
      15:      r = 24'sd32;
      16:      r = 24'sd16;
      17:      r = 24'sd8;
      18:      r = 24'sd4;
      19:      r = 24'sd2;
      20:      r = 24'sd1;
      default: r = 24'sd0;
    endcase
    return r;
  endfunction

  function automatic trig_t qmul_t(input trig_t a, input trig_t b);
    logic signed [39:0] p;
    p = (40'(a) * 40'(b)) + 40'sd32768;
    return trig_t'(p >>> 16);
  endfunction

  function automatic word_t round_sat(input prod_t p);
    prod_t r;
    r = (p + 52'sd32768) >>> 16;
    if (r > 52'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (r < -52'sd2147483648) begin
      return 32'sh80000000;
    end
    return word_t'(r);
  endfunction

endpackage

@@ design/model_matrix_setup.sv @@
// ----------------------------------------------------------------------------
// model_matrix_setup
// Flow: the inputs are registered on start, then pass the CORDIC stages, the sine and
// cosine register, the P1 and P2 product registers and the H register; columns 0 to 3
// then go through the multiply register to the shared result port, one per cycle.
// A new start is taken only while busy is low; busy goes high after each accepted start.
// Reset: synchronous, clears all valid bits and the column sequencer.
// ----------------------------------------------------------------------------
module model_matrix_setup import mms_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  angle_t      angle_x,
  input  angle_t      angle_y,
  input  angle_t      angle_z,
  input  word_t       scale_x,
  input  word_t       scale_y,
  input  word_t       scale_z,
  input  word_t       pos_x,
  input  word_t       pos_y,
  input  word_t       pos_z,
  output logic        strobe,
  output logic [1:0]  column_index,
  output word_t       elem0,
  output word_t       elem1,
  output word_t       elem2,
  output word_t       elem3,
  output logic        last_column
);

  logic [1:0] hold;
  logic       take;

  angle_t ang [3];
  item_t  in_item;
  logic   in_v;

  zang_t  zr   [3];
  logic   fl   [3];
  zang_t  z    [3][N_STG+1];
  cw_t    x    [3][N_STG+1];
  cw_t    y    [3][N_STG+1];
  logic   fp   [3][N_STG+1];
  item_t  itm  [N_STG+1];
  logic   cv   [N_STG+1];

  trig_t  sn_c [3];
  trig_t  cs_c [3];
  trig_t  sn   [3];
  trig_t  cs   [3];
  item_t  r_item;
  logic   r_v;

  trig_t  sysx, cysx, cycz, cxsz, sycz, cysz, cxcz, sysz, sycx, cycx, p1_sx, p1_sz, p1_cz;
  item_t  p1_item;
  logic   p1_v;

  trig_t  sysxsz, cysxsz, sysxcz, cyczsx;
  trig_t  p2_cycz, p2_cxsz, p2_sycz, p2_cysz, p2_cxcz, p2_sysz, p2_sycx, p2_cycx, p2_sx;
  item_t  p2_item;
  logic   p2_v;

  trig_t  h    [9];
  item_t  h_item;
  logic   act;
  logic [1:0] col;

  trig_t  opa  [3];
  word_t  opb  [3];
  prod_t  m_p  [3];
  logic   m_v;
  logic [1:0] m_col;

  assign busy = (hold != 2'd0);
  assign take = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold <= 2'd0;
    end else if (take) begin
      hold <= 2'd3;
    end else if (hold != 2'd0) begin
      hold <= hold - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else begin
      in_v <= take;
    end
    if (take) begin
      ang[0]  <= angle_x;
      ang[1]  <= angle_y;
      ang[2]  <= angle_z;
      in_item <= '{scale_x, scale_y, scale_z, pos_x, pos_y, pos_z};
    end
  end

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      logic signed [16:0] a;
      zang_t zz;
      a = 17'(ang[l]);
      if (ang[l] >= 16'(PI_Q12)) begin
        a = a - 17'(TWO_PI_Q12);
      end else if (ang[l] < -16'(PI_Q12)) begin
        a = a + 17'(TWO_PI_Q12);
      end
      zz = {a[15:0], 8'd0};
      fl[l] = 1'b0;
      if (zz > 24'(HALF_PI_Q20)) begin
        zz = zz - 24'(PI_Q20);
        fl[l] = 1'b1;
      end else if (zz < -24'(HALF_PI_Q20)) begin
        zz = zz + 24'(PI_Q20);
        fl[l] = 1'b1;
      end
      zr[l] = zz;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= N_STG; i++) begin
        cv[i] <= 1'b0;
      end
    end else begin
      cv[0] <= in_v;
      for (int i = 0; i < N_STG; i++) begin
        cv[i+1] <= cv[i];
      end
    end
    itm[0] <= in_item;
    for (int i = 0; i < N_STG; i++) begin
      itm[i+1] <= itm[i];
    end
    for (int l = 0; l < 3; l++) begin
      z[l][0]  <= zr[l];
      fp[l][0] <= fl[l];
      x[l][0]  <= 34'(GAIN_Q30);
      y[l][0]  <= '0;
      for (int i = 0; i < N_STG; i++) begin
        fp[l][i+1] <= fp[l][i];
        if (z[l][i] >= 0) begin
          x[l][i+1] <= x[l][i] - (y[l][i] >>> i);
          y[l][i+1] <= y[l][i] + (x[l][i] >>> i);
          z[l][i+1] <= z[l][i] - atan_q20(i);
        end else begin
          x[l][i+1] <= x[l][i] + (y[l][i] >>> i);
          y[l][i+1] <= y[l][i] - (x[l][i] >>> i);
          z[l][i+1] <= z[l][i] + atan_q20(i);
        end
      end
    end
  end

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      cw_t xr, yr;
      xr = (x[l][N_STG] + 34'sd8192) >>> 14;
      yr = (y[l][N_STG] + 34'sd8192) >>> 14;
      cs_c[l] = fp[l][N_STG] ? -trig_t'(xr) : trig_t'(xr);
      sn_c[l] = fp[l][N_STG] ? -trig_t'(yr) : trig_t'(yr);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r_v  <= 1'b0;
      p1_v <= 1'b0;
      p2_v <= 1'b0;
    end else begin
      r_v  <= cv[N_STG];
      p1_v <= r_v;
      p2_v <= p1_v;
    end
    sn     <= sn_c;
    cs     <= cs_c;
    r_item <= itm[N_STG];

    sysx    <= qmul_t(sn[1], sn[0]);
    cysx    <= qmul_t(cs[1], sn[0]);
    cycz    <= qmul_t(cs[1], cs[2]);
    cxsz    <= qmul_t(cs[0], sn[2]);
    sycz    <= qmul_t(sn[1], cs[2]);
    cysz    <= qmul_t(cs[1], sn[2]);
    cxcz    <= qmul_t(cs[0], cs[2]);
    sysz    <= qmul_t(sn[1], sn[2]);
    sycx    <= qmul_t(sn[1], cs[0]);
    cycx    <= qmul_t(cs[1], cs[0]);
    p1_sx   <= sn[0];
    p1_sz   <= sn[2];
    p1_cz   <= cs[2];
    p1_item <= r_item;

    sysxsz  <= qmul_t(sysx, p1_sz);
    cysxsz  <= qmul_t(cysx, p1_sz);
    sysxcz  <= qmul_t(sysx, p1_cz);
    cyczsx  <= qmul_t(cycz, p1_sx);
    p2_cycz <= cycz;
    p2_cxsz <= cxsz;
    p2_sycz <= sycz;
    p2_cysz <= cysz;
    p2_cxcz <= cxcz;
    p2_sysz <= sysz;
    p2_sycx <= sycx;
    p2_cycx <= cycx;
    p2_sx   <= p1_sx;
    p2_item <= p1_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      act <= 1'b0;
      col <= 2'd0;
    end else if (p2_v) begin
      act <= 1'b1;
      col <= 2'd0;
    end else if (act) begin
      col <= col + 2'd1;
      if (col == 2'd3) begin
        act <= 1'b0;
      end
    end
    if (p2_v) begin
      h[0]   <= p2_cycz + sysxsz;
      h[1]   <= p2_cxsz;
      h[2]   <= cysxsz - p2_sycz;
      h[3]   <= sysxcz - p2_cysz;
      h[4]   <= p2_cxcz;
      h[5]   <= cyczsx + p2_sysz;
      h[6]   <= p2_sycx;
      h[7]   <= -p2_sx;
      h[8]   <= p2_cycx;
      h_item <= p2_item;
    end
  end

  always_comb begin
    unique case (col)
      2'd0: begin
        opa = '{h[0], h[1], h[2]};
        opb = '{h_item.scale_x, h_item.scale_x, h_item.scale_x};
      end
      2'd1: begin
        opa = '{h[3], h[4], h[5]};
        opb = '{h_item.scale_y, h_item.scale_y, h_item.scale_y};
      end
      2'd2: begin
        opa = '{h[6], h[7], h[8]};
        opb = '{h_item.scale_z, h_item.scale_z, h_item.scale_z};
      end
      default: begin
        opa = '{20'(ONE_Q16), 20'(ONE_Q16), 20'(ONE_Q16)};
        opb = '{h_item.pos_x, h_item.pos_y, h_item.pos_z};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_v    <= 1'b0;
      strobe <= 1'b0;
    end else begin
      m_v    <= act;
      strobe <= m_v;
    end
    m_col <= col;
    for (int k = 0; k < 3; k++) begin
      m_p[k] <= 52'(opa[k]) * 52'(opb[k]);
    end
    column_index <= m_col;
    elem0        <= round_sat(m_p[0]);
    elem1        <= round_sat(m_p[1]);
    elem2        <= round_sat(m_p[2]);
    elem3        <= (m_col == 2'd3) ? 32'(ONE_Q16) : 32'sd0;
    last_column  <= (m_col == 2'd3);
  end

endmodule
